// ===== rtl/rrr_pkg.sv =====
// ----------------------------------------------------------------------------
// rrr_pkg
// Shared types and constants for the ROM read request resync core.
// ----------------------------------------------------------------------------
`default_nettype none

package rrr_pkg;

  // Request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_RX    = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  // Result kinds carried in the output tuser
  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DONE = 2'd2,
    KIND_RSVD = 2'd3
  } out_kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_START_ADDR = 2'd0,
    REG_END_ADDR   = 2'd1,
    REG_RETRY      = 2'd2,
    REG_SYNC_LIMIT = 2'd3
  } reg_idx_e;

  localparam logic [7:0]  ReqLead       = 8'h78;
  localparam logic [7:0]  ReqTail       = 8'h00;
  localparam logic [15:0] StartAddrRst  = 16'd0;
  localparam logic [16:0] EndAddrRst    = 17'h10000;
  localparam logic [7:0]  RetryRst      = 8'd100;
  localparam logic [5:0]  SyncLimitRst  = 6'd10;
  localparam int unsigned MaxBeats      = 5;
  localparam int unsigned CntBits       = 3;

  typedef struct packed {
    logic [15:0] start_address;
    logic [16:0] end_address;
    logic [7:0]  retry_ticks;
    logic [5:0]  sync_loss_limit;
  } cfg_t;

  // One result beat
  typedef struct packed {
    out_kind_e   kind;
    logic [7:0]  data;
    logic [15:0] addr;
  } beat_t;

  // Group of beats handed from the step logic to the output buffer
  typedef struct packed {
    logic                  load;
    logic [CntBits-1:0]    cnt;
    beat_t [MaxBeats-1:0]  beats;
  } grp_t;

endpackage

`default_nettype wire

// ===== rtl/rrr_step.sv =====
// ----------------------------------------------------------------------------
// rrr_step
// Link state (window, sync, address, retry count) and the single-pass
// update that turns one accepted item into a group of result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module rrr_step #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 accept_i,
  input  wire  [1:0]          req_type_i,
  input  wire  [7:0]          rx_byte_i,
  input  rrr_pkg::cfg_t       cfg_i,
  output rrr_pkg::grp_t       grp_o
);
  import rrr_pkg::*;

  localparam logic [15:0] AddrMask = 16'((32'd1 << ADDR_BITS) - 32'd1);

  logic [7:0]  win_q [3];
  logic [7:0]  win_d [3];
  logic [1:0]  fill_q, fill_d;
  logic        sync_q, sync_d;
  logic [5:0]  mm_q, mm_d;
  logic [16:0] cur_q, cur_d;
  logic [7:0]  per_q, per_d;
  logic        busy_q, busy_d;

  logic [1:0]  fill_c;
  logic [15:0] a_cur, a_nxt;
  logic [16:0] cur_inc;
  logic [6:0]  mm_inc;
  logic [7:0]  per_inc;
  logic        match;
  grp_t        grp;

  // Fill request beats for an address starting at a slot
  function automatic void put_req(inout beat_t [MaxBeats-1:0] b, input int unsigned s,
                                  input logic [15:0] a);
    b[s]     = '{kind: KIND_TX, data: ReqLead,  addr: a};
    b[s + 1] = '{kind: KIND_TX, data: a[15:8],  addr: a};
    b[s + 2] = '{kind: KIND_TX, data: a[7:0],   addr: a};
    b[s + 3] = '{kind: KIND_TX, data: ReqTail,  addr: a};
  endfunction

  assign fill_c  = (fill_q > 2'd2) ? 2'd2 : fill_q;
  assign a_cur   = cur_q[15:0] & AddrMask;
  assign cur_inc = cur_q + 17'd1;
  assign a_nxt   = cur_inc[15:0] & AddrMask;
  assign mm_inc  = {1'b0, mm_q} + 7'd1;
  assign per_inc = per_q + 8'd1;
  assign match   = (win_q[0] == a_cur[15:8]) && (win_q[1] == a_cur[7:0]);

  // Next state and result group
  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    sync_d  = sync_q;
    mm_d    = mm_q;
    cur_d   = cur_q;
    per_d   = per_q;
    busy_d  = busy_q;
    grp     = '0;
    unique case (req_type_e'(req_type_i))
      REQ_START: begin
        win_d  = '{8'd0, 8'd0, 8'd0};
        fill_d = 2'd0;
        sync_d = 1'b0;
        mm_d   = 6'd0;
        cur_d  = {1'b0, cfg_i.start_address};
        per_d  = 8'd0;
        if ({1'b0, cfg_i.start_address} < cfg_i.end_address) begin
          busy_d  = 1'b1;
          grp.cnt = 3'd4;
          put_req(grp.beats, 0, cfg_i.start_address & AddrMask);
        end else begin
          busy_d   = 1'b0;
          grp.cnt  = 3'd1;
          grp.beats[0] = '{kind: KIND_DONE, data: 8'd0,
                           addr: cfg_i.start_address & AddrMask};
        end
      end
      REQ_RX: begin
        if (busy_q) begin
          win_d[fill_c] = rx_byte_i;
          fill_d        = fill_c + 2'd1;
          if (fill_c == 2'd2) begin
            if (match) begin
              fill_d = 2'd0;
              sync_d = 1'b1;
              mm_d   = 6'd0;
              cur_d  = cur_inc;
              per_d  = 8'd0;
              grp.beats[0] = '{kind: KIND_DATA, data: rx_byte_i, addr: a_cur};
              if (cur_inc < cfg_i.end_address) begin
                grp.cnt = 3'd5;
                put_req(grp.beats, 1, a_nxt);
              end else begin
                busy_d  = 1'b0;
                grp.cnt = 3'd2;
                grp.beats[1] = '{kind: KIND_DONE, data: 8'd0, addr: a_nxt};
              end
            end else begin
              if (sync_q) begin
                fill_d = 2'd0;
              end else begin
                win_d[0] = win_q[1];
                win_d[1] = rx_byte_i;
                fill_d   = 2'd2;
              end
              if (mm_inc > {1'b0, cfg_i.sync_loss_limit}) begin
                sync_d = 1'b0;
                mm_d   = 6'd0;
              end else begin
                mm_d = mm_inc[5:0];
              end
            end
          end
        end
      end
      REQ_TICK: begin
        if (busy_q) begin
          per_d = per_inc;
          if (per_inc == cfg_i.retry_ticks) begin
            per_d   = 8'd0;
            grp.cnt = 3'd4;
            put_req(grp.beats, 0, a_cur);
          end
        end
      end
      default: begin
      end
    endcase
    grp.load = accept_i && (grp.cnt != 3'd0);
  end

  assign grp_o = grp;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '{8'd0, 8'd0, 8'd0};
      fill_q <= 2'd0;
      sync_q <= 1'b0;
      mm_q   <= 6'd0;
      cur_q  <= 17'd0;
      per_q  <= 8'd0;
      busy_q <= 1'b0;
    end else if (accept_i) begin
      win_q  <= win_d;
      fill_q <= fill_d;
      sync_q <= sync_d;
      mm_q   <= mm_d;
      cur_q  <= cur_d;
      per_q  <= per_d;
      busy_q <= busy_d;
    end
  end

  // Window never rests full
  a_fill_lt3: assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q != 2'd3)
    else $error("window fill reached three");

  // A finished beat always leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grp.load && (grp.beats[0].kind == KIND_DONE || grp.beats[1].kind == KIND_DONE)
     && grp.cnt <= 3'd2) |=> !busy_q)
    else $error("finished without going idle");

  // Sync is only set by a match, which clears the mismatch count
  a_sync_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sync_q) |-> (mm_q == 6'd0 && fill_q == 2'd0))
    else $error("sync set without clean match");

endmodule

`default_nettype wire

// ===== rtl/rrr_out_buf.sv =====
// ----------------------------------------------------------------------------
// rrr_out_buf
// Holds one group of result beats and plays them out one per cycle while
// ready_i is high, flagging the final beat of the group.
// ----------------------------------------------------------------------------
`default_nettype none

module rrr_out_buf (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  rrr_pkg::grp_t       grp_i,
  output logic                room_o,
  output logic                valid_o,
  input  wire                 ready_i,
  output rrr_pkg::beat_t      beat_o,
  output logic                last_o
);
  import rrr_pkg::*;

  beat_t [MaxBeats-1:0] beats_q;
  logic [CntBits-1:0]   cnt_q, idx_q;
  logic                 take;

  assign valid_o = (cnt_q != '0);
  assign last_o  = valid_o && (idx_q == cnt_q - 3'd1);
  assign beat_o  = beats_q[idx_q];
  assign take    = valid_o && ready_i;
  assign room_o  = !valid_o || (take && last_o);

  // Beat storage, loaded whole
  always_ff @(posedge clk_i) begin
    if (grp_i.load) begin
      beats_q <= grp_i.beats;
    end
  end

  // Count and play-out index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (grp_i.load) begin
      cnt_q <= grp_i.cnt;
      idx_q <= '0;
    end else if (take) begin
      if (last_o) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (idx_q < cnt_q && cnt_q <= 3'(MaxBeats)))
    else $error("play-out index out of range");

  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_i.load |-> room_o)
    else $error("group loaded over pending beats");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> $stable(idx_q) && $stable(cnt_q))
    else $error("stalled beat index moved");

endmodule

`default_nettype wire

// ===== rtl/rom_read_request_resync_core.sv =====
// ----------------------------------------------------------------------------
// rom_read_request_resync_core
// Reads a ROM range over a serial link: sends address requests, matches
// returned byte tuples, keeps sync and resends on retry timeout.
//
//   channel | dir | beat fields
//   s_axis  | in  | tuser: req_type[1:0]; tdata: rx_byte[7:0]
//   m_axis  | out | tuser: out_kind[1:0]; tdata: out_byte, out_address; tlast
//   apb     | in  | 4 regs at 0x0/0x4/0x8/0xC, write at access phase
//
// An accepted item updates the link state in the same edge and loads its
// result group (0 to 5 beats) into the output buffer; beats leave one per
// cycle while m_axis_tready is high. An item is taken every cycle while its
// predecessor produced at most one beat and the output is not stalled; an
// item with more beats holds the input until its last beat leaves the single
// output port. Reset clears the link state, counters and config to defaults,
// but not the beat storage. A stalled output holds its beat and blocks input.
// ----------------------------------------------------------------------------
`default_nettype none

module rom_read_request_resync_core #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire  [1:0]  s_axis_tuser,   // [1:0] req_type
  // output stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] out_address
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast,
  // config
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrr_pkg::*;

  cfg_t  cfg_q;
  grp_t  grp;
  beat_t beat;
  logic  accept;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_address   <= StartAddrRst;
      cfg_q.end_address     <= EndAddrRst;
      cfg_q.retry_ticks     <= RetryRst;
      cfg_q.sync_loss_limit <= SyncLimitRst;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_START_ADDR: cfg_q.start_address   <= pwdata[15:0];
        REG_END_ADDR:   cfg_q.end_address     <= pwdata[16:0];
        REG_RETRY:      cfg_q.retry_ticks     <= pwdata[7:0];
        REG_SYNC_LIMIT: cfg_q.sync_loss_limit <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_START_ADDR: prdata = {16'd0, cfg_q.start_address};
      REG_END_ADDR:   prdata = {15'd0, cfg_q.end_address};
      REG_RETRY:      prdata = {24'd0, cfg_q.retry_ticks};
      REG_SYNC_LIMIT: prdata = {26'd0, cfg_q.sync_loss_limit};
      default:        prdata = 32'd0;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  rrr_step #(
    .ADDR_BITS (ADDR_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (s_axis_tuser),
    .rx_byte_i  (s_axis_tdata),
    .cfg_i      (cfg_q),
    .grp_o      (grp)
  );

  rrr_out_buf u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .grp_i   (grp),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .beat_o  (beat),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {beat.addr, beat.data};
  assign m_axis_tuser = beat.kind;

endmodule

`default_nettype wire
